[rtl/dxt_texture_block_decoder_defines.svh]
// Assertion macros for the DXT block decoder.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DXT_TEXTURE_BLOCK_DECODER_DEFINES_SVH
`define DXT_TEXTURE_BLOCK_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define DXT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dxt decoder check failed");
`define DXT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dxt decoder check failed");
`else
`define DXT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DXT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/dxt_pkg.sv]
// Shared types and helpers for the DXT block decoder.
// No dependencies; used by dxt_palette, dxt_texture_block_decoder, dxt_row_checker and tb_top.
`default_nettype none

package dxt_pkg;

  localparam int BLOCK_EDGE = 4;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_t;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] color_block;
    logic [63:0] alpha_block;
  } in_t;

  typedef struct packed {
    logic [31:0] texel_left;
    logic [31:0] texel_second;
    logic [31:0] texel_third;
    logic [31:0] texel_right;
    logic [1:0]  row_in_block;
    logic [9:0]  block_column;
    logic [9:0]  block_line;
    logic        last_row;
    logic        image_done;
  } out_t;

  // Decoded palettes of one block: RGBA8 colour entries and 8-bit alpha entries.
  typedef struct packed {
    logic [3:0][31:0] color;
    logic [7:0][7:0]  alpha;
  } pal_t;

  // floor(x / d) for x < 2048 via a 16-bit reciprocal, which undershoots by
  // at most one; the remainder check fixes that.
  function automatic logic [7:0] div_small(input logic [10:0] x, input logic [2:0] d,
                                           input logic [15:0] recip);
    logic [26:0] prod;
    logic [10:0] q;
    logic [13:0] back;
    logic [10:0] rem;
    prod = 27'(x) * 27'(recip);
    q    = prod[26:16];
    back = 14'(q) * 14'(d);
    rem  = x - back[10:0];
    if (rem >= 11'(d)) begin
      q = q + 11'd1;
    end
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

[rtl/dxt_palette.sv]
// Colour and alpha palette builder for one DXT block (combinational).
// Depends on dxt_pkg.
`default_nettype none

module dxt_palette (
  input  dxt_pkg::in_t  blk,
  input  dxt_pkg::fmt_t fmt,
  output dxt_pkg::pal_t pal
);
  import dxt_pkg::*;

  localparam logic [15:0] RECIP3 = 16'd21845;
  localparam logic [15:0] RECIP5 = 16'd13107;
  localparam logic [15:0] RECIP7 = 16'd9362;

  logic [15:0]     e0, e1;
  logic [2:0][7:0] c0, c1;  // index 0 red, 1 green, 2 blue
  logic [2:0][7:0] p2, p3;
  logic            four;
  logic [7:0]      a0, a1;
  logic [10:0]     asum;

  function automatic logic [2:0][7:0] expand565(input logic [15:0] c);
    logic [2:0][7:0] rgb;
    rgb[0] = {c[15:11], c[15:13]};
    rgb[1] = {c[10:5], c[10:9]};
    rgb[2] = {c[4:0], c[4:2]};
    return rgb;
  endfunction

  always_comb begin
    e0   = blk.color_block[15:0];
    e1   = blk.color_block[31:16];
    c0   = expand565(e0);
    c1   = expand565(e1);
    four = (fmt != FMT_DXT1) || (e0 > e1);
    for (int ch = 0; ch < 3; ch++) begin
      if (four) begin
        p2[ch] = div_small({2'b0, c0[ch], 1'b0} + {3'b0, c1[ch]}, 3'd3, RECIP3);
        p3[ch] = div_small({3'b0, c0[ch]} + {2'b0, c1[ch], 1'b0}, 3'd3, RECIP3);
      end else begin
        p2[ch] = 8'(({1'b0, c0[ch]} + {1'b0, c1[ch]}) >> 1);
        p3[ch] = 8'd0;
      end
    end
    pal.color[0] = {8'hFF, c0[2], c0[1], c0[0]};
    pal.color[1] = {8'hFF, c1[2], c1[1], c1[0]};
    pal.color[2] = {8'hFF, p2[2], p2[1], p2[0]};
    pal.color[3] = four ? {8'hFF, p3[2], p3[1], p3[0]} : 32'd0;

    // DXT5 alpha: eight-value ramp when a0 > a1, else six values plus 0 and 255
    a0 = blk.alpha_block[7:0];
    a1 = blk.alpha_block[15:8];
    pal.alpha[0] = a0;
    pal.alpha[1] = a1;
    asum = 11'd0;
    for (int k = 1; k <= 6; k++) begin
      if (a0 > a1) begin
        asum = 11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k);
        pal.alpha[k + 1] = div_small(asum, 3'd7, RECIP7);
      end else if (k <= 4) begin
        asum = 11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k);
        pal.alpha[k + 1] = div_small(asum, 3'd5, RECIP5);
      end else begin
        pal.alpha[k + 1] = (k == 5) ? 8'd0 : 8'd255;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/dxt_texture_block_decoder.sv]
// DXT1/DXT3/DXT5 block decoder top level: input register, palette register, row output.
// Depends on dxt_pkg, dxt_palette and dxt_texture_block_decoder_defines.svh.
//
// One compressed 4x4 block is taken per input transfer and comes out as four
// output transfers, one texel row each, top row first. The output register
// emits one row per cycle while out_stall is low; a block passes the input
// and palette registers first. A new block is taken while the previous one
// is still being emitted. The format and image size registers are written
// over the APB port; the user must write them only while no block is in flight,
// which the block does not enforce. The raster position counters run from the
// top left block and wrap to zero after the last block of the image.
`default_nettype none
`include "dxt_texture_block_decoder_defines.svh"

module dxt_texture_block_decoder #(
  parameter int MAX_SIDE_BLOCKS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dxt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dxt_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import dxt_pkg::*;

  localparam int CW = (MAX_SIDE_BLOCKS > 1) ? $clog2(MAX_SIDE_BLOCKS) : 1;
  localparam int SW = (CW + 1 > 11) ? CW + 1 : 11;

  // configuration
  logic [1:0]  format_mode;
  logic [10:0] width_blocks;
  logic [10:0] height_blocks;
  reg_idx_t    reg_idx;
  logic        cfg_we;
  fmt_t        fmt_eff;

  // raster counters
  logic [CW-1:0] col_cnt, line_cnt;
  logic [CW-1:0] col_cnt_next, line_cnt_next;
  logic [SW-1:0] w_eff, h_eff, col_inc, line_inc;
  logic          at_right, at_bottom;

  // input register
  logic       s0v;
  in_t        s0_blk;
  logic [9:0] s0_col, s0_line;
  logic       s0_done;

  // palette register
  logic        s1v;
  pal_t        s1_pal;
  logic [31:0] s1_cidx;
  logic [63:0] s1_ab;
  fmt_t        s1_fmt;
  logic [9:0]  s1_col, s1_line;
  logic        s1_done;
  logic [1:0]  rc;

  logic in_xfer, out_free, s1_free, s0_move, row_load;
  pal_t pal;
  out_t out_next;

  logic [7:0]       crow;
  logic [15:0]      a4row;
  logic [11:0]      a3row;
  logic [47:0]      aidx;
  logic [3:0][31:0] tex;
  logic [1:0]       ci;
  logic [3:0]       a4;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_FORMAT: prdata = {30'd0, format_mode};
      REG_WIDTH:  prdata = {21'd0, width_blocks};
      REG_HEIGHT: prdata = {21'd0, height_blocks};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode   <= 2'd0;
      width_blocks  <= 11'd1;
      height_blocks <= 11'd1;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_FORMAT: format_mode   <= pwdata[1:0];
        REG_WIDTH:  width_blocks  <= pwdata[10:0];
        REG_HEIGHT: height_blocks <= pwdata[10:0];
        default:    ;
      endcase
    end
  end

  // code three decodes as DXT1
  assign fmt_eff = (format_mode == FMT_DXT3 || format_mode == FMT_DXT5) ?
                   fmt_t'(format_mode) : FMT_DXT1;

  // ---------------- raster position ----------------
  always_comb begin
    if (width_blocks == 11'd0) begin
      w_eff = SW'(1);
    end else if (SW'(width_blocks) > SW'(MAX_SIDE_BLOCKS)) begin
      w_eff = SW'(MAX_SIDE_BLOCKS);
    end else begin
      w_eff = SW'(width_blocks);
    end
    if (height_blocks == 11'd0) begin
      h_eff = SW'(1);
    end else if (SW'(height_blocks) > SW'(MAX_SIDE_BLOCKS)) begin
      h_eff = SW'(MAX_SIDE_BLOCKS);
    end else begin
      h_eff = SW'(height_blocks);
    end
    col_inc   = SW'(col_cnt) + SW'(1);
    line_inc  = SW'(line_cnt) + SW'(1);
    at_right  = col_inc >= w_eff;
    at_bottom = line_inc >= h_eff;
    if (at_right) begin
      col_cnt_next  = '0;
      line_cnt_next = at_bottom ? '0 : CW'(line_inc);
    end else begin
      col_cnt_next  = CW'(col_inc);
      line_cnt_next = line_cnt;
    end
  end

  // ---------------- flow control ----------------
  assign out_free = !out_valid || !out_stall;
  assign row_load = s1v && out_free;
  assign s1_free  = !s1v || (out_free && rc == 2'd3);
  assign s0_move  = s0v && s1_free;
  assign in_stall = s0v && !s1_free;
  assign in_xfer  = in_valid && !in_stall;

  dxt_palette u_palette (
    .blk (s0_blk),
    .fmt (fmt_eff),
    .pal (pal)
  );

  // ---------------- row select ----------------
  always_comb begin
    aidx  = s1_ab[63:16];
    crow  = s1_cidx[{rc, 3'b000} +: 8];
    a4row = s1_ab[{rc, 4'b0000} +: 16];
    a3row = aidx[6'(rc) * 6'd12 +: 12];
    ci    = 2'd0;
    a4    = 4'd0;
    for (int c = 0; c < BLOCK_EDGE; c++) begin
      ci     = crow[2*c +: 2];
      tex[c] = s1_pal.color[ci];
      case (s1_fmt)
        FMT_DXT3: begin
          a4 = a4row[4*c +: 4];
          tex[c][31:24] = {a4, a4};
        end
        FMT_DXT5: tex[c][31:24] = s1_pal.alpha[a3row[3*c +: 3]];
        default:  ;
      endcase
    end
    out_next.texel_left   = tex[0];
    out_next.texel_second = tex[1];
    out_next.texel_third  = tex[2];
    out_next.texel_right  = tex[3];
    out_next.row_in_block = rc;
    out_next.block_column = s1_col;
    out_next.block_line   = s1_line;
    out_next.last_row     = (rc == 2'd3);
    out_next.image_done   = (rc == 2'd3) && s1_done;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      line_cnt  <= '0;
      s0v       <= 1'b0;
      s1v       <= 1'b0;
      rc        <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_cnt  <= col_cnt_next;
        line_cnt <= line_cnt_next;
      end
      if (in_xfer) begin
        s0v <= 1'b1;
      end else if (s0_move) begin
        s0v <= 1'b0;
      end
      if (s0_move) begin
        s1v <= 1'b1;
      end else if (s1_free) begin
        s1v <= 1'b0;
      end
      if (row_load) begin
        rc <= rc + 2'd1;
      end
      if (row_load) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_blk  <= in_data;
      s0_col  <= 10'(col_cnt);
      s0_line <= 10'(line_cnt);
      s0_done <= at_right && at_bottom;
    end
    if (s0_move) begin
      s1_pal  <= pal;
      s1_cidx <= s0_blk.color_block[63:32];
      s1_ab   <= s0_blk.alpha_block;
      s1_fmt  <= fmt_eff;
      s1_col  <= s0_col;
      s1_line <= s0_line;
      s1_done <= s0_done;
    end
    if (row_load) begin
      out_data <= out_next;
    end
  end

  // ---------------- checks ----------------
  `DXT_ASSERT_IMPLY(a_rows_need_block, clk, rst, rc != 2'd0, s1v)
  `DXT_ASSERT_IMPLY(a_done_on_last_row, clk, rst, out_valid && out_data.image_done,
                    out_data.last_row)
  `DXT_ASSERT_NEXT(a_rows_back_to_back, clk, rst,
                   out_valid && !out_stall && !out_data.last_row, out_valid)
  `DXT_ASSERT_IMPLY(a_column_in_range, clk, rst, 1'b1,
                    SW'(col_cnt) < SW'(MAX_SIDE_BLOCKS))

endmodule

`default_nettype wire

[tb/dxt_row_checker.sv]
// Scoreboard for the DXT block decoder: mirrors the APB register writes, predicts
// the four texel rows of every accepted block and compares each output transfer.
// Depends on dxt_pkg for the payload structs, format codes and register indexes.
module dxt_row_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  dxt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  dxt_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output int            fail_count,
  output int            rows_pending
);
  import dxt_pkg::*;

  out_t        expected_rows[$];
  logic [1:0]  fmt_reg;
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  int          col_pos;
  int          line_pos;

  function automatic int side_blocks(input logic [10:0] v);
    if (v == 11'd0) return 1;
    if (v > 11'd1024) return 1024;
    return int'(v);
  endfunction

  // RGB565 -> RGB888 by replicating the top bits; [0] red, [1] green, [2] blue
  function automatic logic [2:0][7:0] widen_565(input logic [15:0] c);
    logic [2:0][7:0] rgb;
    rgb[0] = {c[15:11], c[15:13]};
    rgb[1] = {c[10:5], c[10:9]};
    rgb[2] = {c[4:0], c[4:2]};
    return rgb;
  endfunction

  function automatic void decode_block(input in_t blk);
    fmt_t             fmt;
    logic [2:0][7:0]  c0;
    logic [2:0][7:0]  c1;
    logic [3:0][31:0] colour;
    logic [7:0][7:0]  alpha;
    logic [3:0][31:0] texels;
    logic [1:0]       ci;
    logic [2:0]       ai;
    logic [3:0]       a4;
    int               a0;
    int               a1;
    int               w;
    int               h;
    int               t;
    bit               at_right;
    bit               at_bottom;
    out_t             row;

    // format code three falls back to DXT1
    fmt = (fmt_reg == FMT_DXT3 || fmt_reg == FMT_DXT5) ? fmt_t'(fmt_reg) : FMT_DXT1;
    w = side_blocks(width_reg);
    h = side_blocks(height_reg);
    at_right  = col_pos + 1 >= w;
    at_bottom = line_pos + 1 >= h;

    c0 = widen_565(blk.color_block[15:0]);
    c1 = widen_565(blk.color_block[31:16]);
    colour[0] = {8'hFF, c0[2], c0[1], c0[0]};
    colour[1] = {8'hFF, c1[2], c1[1], c1[0]};
    if (fmt != FMT_DXT1 || blk.color_block[15:0] > blk.color_block[31:16]) begin
      colour[2] = 32'hFF00_0000;
      colour[3] = 32'hFF00_0000;
      for (int ch = 0; ch < 3; ch++) begin
        colour[2][8*ch +: 8] = 8'((2 * int'(c0[ch]) + int'(c1[ch])) / 3);
        colour[3][8*ch +: 8] = 8'((int'(c0[ch]) + 2 * int'(c1[ch])) / 3);
      end
    end else begin
      // three-colour mode: index 3 is transparent black
      colour[2] = 32'hFF00_0000;
      colour[3] = '0;
      for (int ch = 0; ch < 3; ch++) begin
        colour[2][8*ch +: 8] = 8'((int'(c0[ch]) + int'(c1[ch])) / 2);
      end
    end

    a0 = int'(blk.alpha_block[7:0]);
    a1 = int'(blk.alpha_block[15:8]);
    alpha[0] = 8'(a0);
    alpha[1] = 8'(a1);
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        alpha[k+1] = 8'(((7 - k) * a0 + k * a1) / 7);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        alpha[k+1] = 8'(((5 - k) * a0 + k * a1) / 5);
      end
      alpha[6] = 8'h00;
      alpha[7] = 8'hFF;
    end

    for (int r = 0; r < BLOCK_EDGE; r++) begin
      for (int c = 0; c < BLOCK_EDGE; c++) begin
        t = r * BLOCK_EDGE + c;
        ci = blk.color_block[32 + 2*t +: 2];
        texels[c] = colour[ci];
        if (fmt == FMT_DXT3) begin
          a4 = blk.alpha_block[4*t +: 4];
          texels[c][31:24] = 8'(17 * int'(a4));
        end else if (fmt == FMT_DXT5) begin
          ai = blk.alpha_block[16 + 3*t +: 3];
          texels[c][31:24] = alpha[ai];
        end
      end
      row.texel_left   = texels[0];
      row.texel_second = texels[1];
      row.texel_third  = texels[2];
      row.texel_right  = texels[3];
      row.row_in_block = 2'(r);
      row.block_column = 10'(col_pos);
      row.block_line   = 10'(line_pos);
      row.last_row     = (r == BLOCK_EDGE - 1);
      row.image_done   = (r == BLOCK_EDGE - 1) && at_right && at_bottom;
      expected_rows.push_back(row);
    end

    // a counter past the edge after a size rewrite wraps like one at the edge
    if (at_right) begin
      col_pos  = 0;
      line_pos = at_bottom ? 0 : line_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      expected_rows.delete();
      fmt_reg    = FMT_DXT1;
      width_reg  = 11'd1;
      height_reg = 11'd1;
      col_pos    = 0;
      line_pos   = 0;
      fail_count = 0;
      rows_pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("texel row transfer with no block outstanding");
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("texel_left", want.texel_left, out_data.texel_left);
          check_field("texel_second", want.texel_second, out_data.texel_second);
          check_field("texel_third", want.texel_third, out_data.texel_third);
          check_field("texel_right", want.texel_right, out_data.texel_right);
          check_field("row_in_block", 32'(want.row_in_block), 32'(out_data.row_in_block));
          check_field("block_column", 32'(want.block_column), 32'(out_data.block_column));
          check_field("block_line", 32'(want.block_line), 32'(out_data.block_line));
          check_field("last_row", 32'(want.last_row), 32'(out_data.last_row));
          check_field("image_done", 32'(want.image_done), 32'(out_data.image_done));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_FORMAT: fmt_reg    = pwdata[1:0];
          REG_WIDTH:  width_reg  = pwdata[10:0];
          REG_HEIGHT: height_reg = pwdata[10:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        decode_block(in_data);
      end
      rows_pending <= expected_rows.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the DXT block decoder bench: clock, reset, block and APB stimulus, receiver stalls.
// Depends on dxt_pkg, the decoder RTL and dxt_row_checker, which does all checking.
module tb_top;
  import dxt_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_BLOCKS  = 340;
  localparam logic [1:0] FMT_UNDEFINED  = 2'd3;
  localparam logic [3:0] ADDR_UNMAPPED  = 4'hC;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          rows_pending;
  int          idle_cycles;
  bit          tx_calm;
  bit          rx_calm;

  dxt_texture_block_decoder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dxt_row_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(mismatches), .rows_pending(rows_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [3:0] reg_addr(input reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  // leaves psel high so back-to-back writes go straight to the next setup phase
  task automatic apb_write(input logic [3:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_image(input logic [1:0] fmt, input int w, input int h);
    apb_write(reg_addr(REG_FORMAT), 32'(fmt));
    apb_write(reg_addr(REG_WIDTH), 32'(w));
    apb_write(reg_addr(REG_HEIGHT), 32'(h));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_block(input in_t blk);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every predicted row has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
  endtask

  function automatic in_t random_block();
    in_t blk;
    blk.color_block = {$urandom, $urandom};
    blk.alpha_block = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) blk.color_block[31:16] = blk.color_block[15:0];
    if ($urandom_range(0, 7) == 0) blk.alpha_block[15:8] = blk.alpha_block[7:0];
    return blk;
  endfunction

  function automatic int pick_side();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1024;
      2: return 2047;
      3: return 1025;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic in_t make_block(input logic [63:0] colour, input logic [63:0] alpha);
    in_t blk;
    blk.color_block = colour;
    blk.alpha_block = alpha;
    return blk;
  endfunction

  // receiver: random stall before every row transfer
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          sent;
    int          n;
    logic [1:0]  fmt;
    logic [47:0] ramp;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    // alpha indices 0..7 twice over the sixteen texels
    ramp = 48'hFAC688_FAC688;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // DXT1: four-colour, three-colour, transparent black, equal endpoints
    set_image(FMT_DXT1, 2, 2);
    send_block(make_block('0, '0));
    send_block(make_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom}));
    send_block(make_block({32'hFFFF_FFFF, 16'hFFFF, 16'h0000}, '0));
    send_block(make_block({32'hE4E4_E4E4, 16'h7BEF, 16'h7BEF}, '1));
    send_block(make_block('1, '1));
    send_block(make_block({32'h1B1B_1B1B, 16'hF800, 16'h07E0}, '0));

    drain();
    set_image(FMT_DXT3, 3, 1);
    send_block(make_block({32'hFFFF_FFFF, 16'hFFFF, 16'h0000}, '0));
    send_block(make_block({32'h1B1B_1B1B, 16'h001F, 16'hF800}, '1));
    send_block(make_block({$urandom, $urandom}, 64'hFEDC_BA98_7654_3210));

    // DXT5: eight-value palette, six-value palette, equal endpoints
    drain();
    set_image(FMT_DXT5, 1, 1);
    send_block(make_block({$urandom, $urandom}, {ramp, 8'h00, 8'hFF}));
    send_block(make_block({$urandom, $urandom}, {ramp, 8'hFF, 8'h00}));
    send_block(make_block({$urandom, $urandom}, {ramp, 8'h80, 8'h80}));
    send_block(make_block({$urandom, $urandom}, {ramp, 8'hFE, 8'h01}));
    send_block(make_block('1, '1));

    // undefined format code and zero sizes
    drain();
    set_image(FMT_UNDEFINED, 0, 0);
    send_block(random_block());
    send_block(make_block({32'hFFFF_FFFF, 16'hFFFF, 16'h0000}, '1));

    drain();
    set_image(FMT_DXT5, 2047, 2047);
    send_block(random_block());
    send_block(random_block());

    // unmapped address, then shrink the width under a column counter past the new edge
    drain();
    apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    set_image(FMT_DXT1, 5, 2);
    repeat (3) send_block(random_block());
    drain();
    set_image(FMT_DXT1, 2, 2);
    repeat (3) send_block(random_block());

    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      drain();
      fmt = ($urandom_range(0, 7) == 0) ? FMT_UNDEFINED : 2'($urandom_range(0, 2));
      set_image(fmt, pick_side(), pick_side());
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 45);
      repeat (n) begin
        send_block(random_block());
        sent++;
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dxt_pkg.sv
rtl/dxt_palette.sv
rtl/dxt_texture_block_decoder.sv
tb/dxt_row_checker.sv
tb/tb_top.sv
